// ===== sv/cdsa_pkg.sv =====
// Shared types, constants and calendar functions for the date set and advance block.
// Used by cdsa_seq, cdsa_dp, calendar_date_set_and_advance and the testbench; depends on nothing.
`default_nettype none

package cdsa_pkg;

    localparam int YEAR_MAX   = 9999;
    localparam int YEAR_RESET = 2000;
    localparam int OFF_LIMIT  = 365;
    localparam int LEN_PLAIN  = 365;
    localparam int LEN_LEAP   = 366;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 10;
    // Working year spans -1 .. YEAR_MAX + 1 and the day count spans -364 .. 731.
    localparam int YR_W    = 16;
    localparam int ACC_W   = 11;

    // Divisibility by 25 through the multiplicative inverse of 25 modulo 2**16.
    localparam logic [15:0] INV25     = 16'd23593;
    localparam logic [15:0] DIV25_LIM = 16'd2621;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_ADV  = 1'b1;

    localparam logic ALU_ADD = 1'b0;
    localparam logic ALU_SUB = 1'b1;

    localparam logic OPND_MONTH = 1'b0;
    localparam logic OPND_YEAR  = 1'b1;

    localparam logic [3:0] MON_JAN = 4'd1;
    localparam logic [3:0] MON_FEB = 4'd2;
    localparam logic [3:0] MON_MAR = 4'd3;
    localparam logic [3:0] MON_APR = 4'd4;
    localparam logic [3:0] MON_MAY = 4'd5;
    localparam logic [3:0] MON_JUN = 4'd6;
    localparam logic [3:0] MON_JUL = 4'd7;
    localparam logic [3:0] MON_AUG = 4'd8;
    localparam logic [3:0] MON_SEP = 4'd9;
    localparam logic [3:0] MON_OCT = 4'd10;
    localparam logic [3:0] MON_NOV = 4'd11;
    localparam logic [3:0] MON_DEC = 4'd12;

    typedef struct packed {
        logic start;
        logic leap_en;
        logic alu_en;
        logic alu_op;
        logic alu_opnd;
        logic m_inc;
        logic m_clr;
        logic y_inc;
        logic y_dec;
        logic commit;
    } cdsa_ctl_t;

    typedef struct packed {
        logic load_valid;
        logic m_lt_cur;
        logic m_lt_12;
        logic acc_gt_mlen;
        logic acc_gt_ylen;
        logic acc_lt_one;
        logic y_in_range;
    } cdsa_sts_t;

    // Gregorian leap rule on the magnitude of the year.
    function automatic logic is_leap(input logic signed [YR_W-1:0] y);
        logic [15:0] ya;
        logic [15:0] prod;
        logic        div25;
        ya    = y[YR_W-1] ? 16'(-y) : 16'(y);
        prod  = 16'(ya * INV25);
        div25 = (prod <= DIV25_LIM);
        return (ya[1:0] == 2'd0) && (!div25 || (ya[3:0] == 4'd0));
    endfunction

    // Month length in days, zero for a month code outside January to December.
    function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DAY_W-1:0] len;
        case (m)
            MON_JAN, MON_MAR, MON_MAY, MON_JUL,
            MON_AUG, MON_OCT, MON_DEC: len = 5'd31;
            MON_APR, MON_JUN, MON_SEP, MON_NOV: len = 5'd30;
            MON_FEB: len = leap ? 5'd29 : 5'd28;
            default: len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

`default_nettype wire

// ===== sv/calendar_date_set_and_advance.sv =====
// Gregorian date register with load and signed day advance; top level of the block.
// A load goes through a leap state and a check state before its result is offered; an advance
// walks the months on the shared adder, with up to 11 steps to form the day of the year
// and up to 11 steps to split it back into month and day.
// Throughput: one item at a time; the next item is taken the cycle after the result leaves.
// Reset (rst_n, asynchronous, active low) sets the date to January 1, 2000, and ok low.
`default_nettype none

module calendar_date_set_and_advance
    import cdsa_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire logic                    in_valid,
    output logic                         in_ready,
    input  wire logic                    command,
    input  wire logic [YEAR_W-1:0]       year_in,
    input  wire logic [MONTH_W-1:0]      month_in,
    input  wire logic [DAY_W-1:0]        day_in,
    input  wire logic signed [OFF_W-1:0] offset_days,
    output logic                         out_valid,
    input  wire logic                    out_ready,
    output logic [YEAR_W-1:0]            year_out,
    output logic [MONTH_W-1:0]           month_out,
    output logic [DAY_W-1:0]             day_out,
    output logic                         ok
);

    // The sequencer owns the handshake. An item is captured into the datapath
    // working registers in the cycle it is accepted, so the input fields need
    // not stay valid afterwards.
    //
    // A load checks the year against the upper limit, the month against
    // January to December and the day against the month length for that
    // year, and commits only when all three pass.
    //
    // An advance clamps the offset to one year either way, adds it to the
    // stored day, then walks the months before the stored one to form the day
    // of the year. At most one year boundary is crossed, after which the leap
    // flag is recomputed for the new year. The day of the year is then split
    // back into month and day one month per cycle. A year outside zero to the
    // upper limit leaves the stored date untouched and reports ok low.
    //
    // The result fields come straight from the stored date and the ok flag,
    // which hold still while the result waits to be taken.

    cdsa_ctl_t ctl;
    cdsa_sts_t sts;

    cdsa_seq u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .command   (command),
        .sts       (sts),
        .ctl       (ctl)
    );

    cdsa_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .ctl         (ctl),
        .command     (command),
        .year_in     (year_in),
        .month_in    (month_in),
        .day_in      (day_in),
        .offset_days (offset_days),
        .sts         (sts),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .ok          (ok)
    );

endmodule

`default_nettype wire

// ===== sv/cdsa_dp.sv =====
// Datapath: stored date, working registers and the shared add/subtract unit.
// Depends on cdsa_pkg; driven by the control word from cdsa_seq.
`default_nettype none

module cdsa_dp
    import cdsa_pkg::*;
(
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire cdsa_ctl_t               ctl,
    input  wire logic                    command,
    input  wire logic [YEAR_W-1:0]       year_in,
    input  wire logic [MONTH_W-1:0]      month_in,
    input  wire logic [DAY_W-1:0]        day_in,
    input  wire logic signed [OFF_W-1:0] offset_days,
    output cdsa_sts_t                    sts,
    output logic [YEAR_W-1:0]            year_out,
    output logic [MONTH_W-1:0]           month_out,
    output logic [DAY_W-1:0]             day_out,
    output logic                         ok
);

    logic signed [YR_W-1:0]  y_reg;
    logic signed [YR_W-1:0]  y_next;
    logic [MONTH_W-1:0]      m_reg;
    logic [MONTH_W-1:0]      m_next;
    logic signed [ACC_W-1:0] acc_reg;
    logic signed [ACC_W-1:0] acc_next;
    logic                    leap_reg;

    logic [YEAR_W-1:0]       cur_year_reg;
    logic [MONTH_W-1:0]      cur_month_reg;
    logic [DAY_W-1:0]        cur_day_reg;
    logic                    ok_reg;

    logic [DAY_W-1:0]        mlen;
    logic signed [ACC_W-1:0] mlen_s;
    logic signed [ACC_W-1:0] ylen_s;
    logic signed [ACC_W-1:0] opnd;
    logic signed [ACC_W-1:0] alu_res;
    logic signed [ACC_W-1:0] off_sat;
    logic signed [ACC_W-1:0] adv_start;

    assign mlen   = month_len(leap_reg, m_reg);
    assign mlen_s = $signed({{(ACC_W-DAY_W){1'b0}}, mlen});
    assign ylen_s = leap_reg ? ACC_W'(LEN_LEAP) : ACC_W'(LEN_PLAIN);

    // The one adder shared by every step of the walk.
    assign opnd    = (ctl.alu_opnd == OPND_YEAR) ? ylen_s : mlen_s;
    assign alu_res = (ctl.alu_op == ALU_SUB) ? (acc_reg - opnd) : (acc_reg + opnd);

    always_comb
    begin
        if (offset_days > OFF_LIMIT)
        begin
            off_sat = ACC_W'(OFF_LIMIT);
        end
        else if (offset_days < -OFF_LIMIT)
        begin
            off_sat = -ACC_W'(OFF_LIMIT);
        end
        else
        begin
            off_sat = {offset_days[OFF_W-1], offset_days};
        end
    end

    assign adv_start = $signed({{(ACC_W-DAY_W){1'b0}}, cur_day_reg}) + off_sat;

    always_comb
    begin
        y_next   = y_reg;
        m_next   = m_reg;
        acc_next = acc_reg;
        if (ctl.start)
        begin
            if (command == CMD_LOAD)
            begin
                y_next   = $signed({{(YR_W-YEAR_W){1'b0}}, year_in});
                m_next   = month_in;
                acc_next = $signed({{(ACC_W-DAY_W){1'b0}}, day_in});
            end
            else
            begin
                y_next   = $signed({{(YR_W-YEAR_W){1'b0}}, cur_year_reg});
                m_next   = MON_JAN;
                acc_next = adv_start;
            end
        end
        else
        begin
            if (ctl.alu_en)
            begin
                acc_next = alu_res;
            end
            if (ctl.m_inc)
            begin
                m_next = m_reg + 4'd1;
            end
            else if (ctl.m_clr)
            begin
                m_next = MON_JAN;
            end
            if (ctl.y_inc)
            begin
                y_next = y_reg + 16'sd1;
            end
            else if (ctl.y_dec)
            begin
                y_next = y_reg - 16'sd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        y_reg   <= y_next;
        m_reg   <= m_next;
        acc_reg <= acc_next;
        if (ctl.leap_en)
        begin
            leap_reg <= is_leap(y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_year_reg  <= YEAR_W'(YEAR_RESET);
            cur_month_reg <= MON_JAN;
            cur_day_reg   <= 5'd1;
            ok_reg        <= 1'b0;
        end
        else
        begin
            if (ctl.start)
            begin
                ok_reg <= 1'b0;
            end
            else if (ctl.commit)
            begin
                cur_year_reg  <= y_reg[YEAR_W-1:0];
                cur_month_reg <= m_reg;
                cur_day_reg   <= acc_reg[DAY_W-1:0];
                ok_reg        <= 1'b1;
            end
        end
    end

    assign sts.load_valid  = (y_reg <= YEAR_MAX) && (mlen != 5'd0) &&
                             (acc_reg >= 11'sd1) && (acc_reg <= mlen_s);
    assign sts.m_lt_cur    = (m_reg < cur_month_reg);
    assign sts.m_lt_12     = (m_reg < MON_DEC);
    assign sts.acc_gt_mlen = (acc_reg > mlen_s);
    assign sts.acc_gt_ylen = (acc_reg > ylen_s);
    assign sts.acc_lt_one  = (acc_reg < 11'sd1);
    assign sts.y_in_range  = (y_reg >= 16'sd0) && (y_reg <= YEAR_MAX);

    assign year_out  = cur_year_reg;
    assign month_out = cur_month_reg;
    assign day_out   = cur_day_reg;
    assign ok        = ok_reg;

endmodule

`default_nettype wire

// ===== sv/cdsa_seq.sv =====
// Sequencer for the load checks and for the date walks on the shared adder.
// Depends on cdsa_pkg; drives cdsa_dp through a control word.
`default_nettype none

module cdsa_seq
    import cdsa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  wire logic      out_ready,
    input  wire logic      command,
    input  wire cdsa_sts_t sts,
    output cdsa_ctl_t      ctl
);

    localparam logic [3:0] S_IDLE      = 4'd0;
    localparam logic [3:0] S_LOAD_LEAP = 4'd1;
    localparam logic [3:0] S_LOAD_CHK  = 4'd2;
    localparam logic [3:0] S_ADV_LEAP  = 4'd3;
    localparam logic [3:0] S_DOY       = 4'd4;
    localparam logic [3:0] S_CROSS     = 4'd5;
    localparam logic [3:0] S_NEW_LEAP  = 4'd6;
    localparam logic [3:0] S_BORROW    = 4'd7;
    localparam logic [3:0] S_SPLIT     = 4'd8;
    localparam logic [3:0] S_OUT       = 4'd9;

    logic [3:0] state_reg;
    logic [3:0] state_next;
    logic       borrow_reg;
    logic       borrow_next;

    always_comb
    begin
        state_next  = state_reg;
        borrow_next = borrow_reg;
        ctl         = '0;
        in_ready    = 1'b0;
        out_valid   = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    ctl.start  = 1'b1;
                    state_next = (command == CMD_LOAD) ? S_LOAD_LEAP : S_ADV_LEAP;
                end
            end
            S_LOAD_LEAP:
            begin
                ctl.leap_en = 1'b1;
                state_next  = S_LOAD_CHK;
            end
            S_LOAD_CHK:
            begin
                ctl.commit = sts.load_valid;
                state_next = S_OUT;
            end
            S_ADV_LEAP:
            begin
                ctl.leap_en = 1'b1;
                state_next  = S_DOY;
            end
            S_DOY:
            begin
                // Sum the lengths of the months before the stored month.
                if (sts.m_lt_cur)
                begin
                    ctl.alu_en   = 1'b1;
                    ctl.alu_op   = ALU_ADD;
                    ctl.alu_opnd = OPND_MONTH;
                    ctl.m_inc    = 1'b1;
                end
                else
                begin
                    state_next = S_CROSS;
                end
            end
            S_CROSS:
            begin
                ctl.m_clr = 1'b1;
                if (sts.acc_gt_ylen)
                begin
                    ctl.alu_en   = 1'b1;
                    ctl.alu_op   = ALU_SUB;
                    ctl.alu_opnd = OPND_YEAR;
                    ctl.y_inc    = 1'b1;
                    borrow_next  = 1'b0;
                    state_next   = S_NEW_LEAP;
                end
                else if (sts.acc_lt_one)
                begin
                    ctl.y_dec   = 1'b1;
                    borrow_next = 1'b1;
                    state_next  = S_NEW_LEAP;
                end
                else
                begin
                    state_next = S_SPLIT;
                end
            end
            S_NEW_LEAP:
            begin
                ctl.leap_en = 1'b1;
                state_next  = borrow_reg ? S_BORROW : S_SPLIT;
            end
            S_BORROW:
            begin
                ctl.alu_en   = 1'b1;
                ctl.alu_op   = ALU_ADD;
                ctl.alu_opnd = OPND_YEAR;
                state_next   = S_SPLIT;
            end
            S_SPLIT:
            begin
                if (!sts.y_in_range)
                begin
                    state_next = S_OUT;
                end
                else if (sts.m_lt_12 && sts.acc_gt_mlen)
                begin
                    ctl.alu_en   = 1'b1;
                    ctl.alu_op   = ALU_SUB;
                    ctl.alu_opnd = OPND_MONTH;
                    ctl.m_inc    = 1'b1;
                end
                else
                begin
                    ctl.commit = 1'b1;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            borrow_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            borrow_reg <= borrow_next;
        end
    end

endmodule

`default_nettype wire

// ===== tb/calendar_date_set_and_advance_tb.sv =====
// Testbench for calendar_date_set_and_advance: loads and day advances with a built-in date predictor.
// Depends on cdsa_pkg (widths, command codes, month names) and the block's RTL; nothing else.
`default_nettype none

module calendar_date_set_and_advance_tb;
    import cdsa_pkg::*;

    // Generous bound on the whole run, in simulation time units, far longer than a clean run needs.
    localparam int RUN_LIMIT    = 5_000_000;
    // Cycles to keep watching after the last expected result, well past the longest advance.
    localparam int SETTLE_CYCLES = 64;
    localparam int RANDOM_ITEMS  = 1250;

    // One input item as the testbench sees it.
    typedef struct {
        logic                    cmd;
        logic [YEAR_W-1:0]       year;
        logic [MONTH_W-1:0]      month;
        logic [DAY_W-1:0]        day;
        logic signed [OFF_W-1:0] offset;
    } date_cmd_t;

    // One result item: the stored date after the command and whether it was carried out.
    typedef struct {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
        logic               ok;
    } date_result_t;

    logic                    clk = 1'b0;
    logic                    rst_n = 1'b0;
    logic                    in_valid = 1'b0;
    logic                    in_ready;
    logic                    command = CMD_LOAD;
    logic [YEAR_W-1:0]       year_in = '0;
    logic [MONTH_W-1:0]      month_in = '0;
    logic [DAY_W-1:0]        day_in = '0;
    logic signed [OFF_W-1:0] offset_days = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [YEAR_W-1:0]       year_out;
    logic [MONTH_W-1:0]      month_out;
    logic [DAY_W-1:0]        day_out;
    logic                    ok;

    // The predictor's copy of the stored date, starting from the reset value.
    logic [YEAR_W-1:0]  held_year = YEAR_W'(YEAR_RESET);
    logic [MONTH_W-1:0] held_month = MON_JAN;
    logic [DAY_W-1:0]   held_day = 5'd1;

    date_result_t expected_dates[$];
    int           error_count = 0;
    // When clear, neither the sender nor the receiver inserts idle cycles.
    bit           gaps_on = 1'b1;

    calendar_date_set_and_advance i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .command     (command),
        .year_in     (year_in),
        .month_in    (month_in),
        .day_in      (day_in),
        .offset_days (offset_days),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .year_out    (year_out),
        .month_out   (month_out),
        .day_out     (day_out),
        .ok          (ok)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Calendar arithmetic for the predictor.
    // ------------------------------------------------------------------

    // Gregorian rule applied to the magnitude, so year -1 counts as a plain year.
    function automatic bit gregorian_leap(input int y);
        int a;
        a = (y < 0) ? -y : y;
        return (a % 4 == 0) && ((a % 100 != 0) || (a % 400 == 0));
    endfunction

    function automatic int days_in_year(input int y);
        return gregorian_leap(y) ? LEN_LEAP : LEN_PLAIN;
    endfunction

    // Zero for a month number outside January to December, which makes any day invalid.
    function automatic int days_in_month(input int y, input int m);
        int len;
        case (m)
            int'(MON_FEB): len = gregorian_leap(y) ? 29 : 28;
            int'(MON_APR), int'(MON_JUN), int'(MON_SEP), int'(MON_NOV): len = 30;
            int'(MON_JAN), int'(MON_MAR), int'(MON_MAY), int'(MON_JUL),
            int'(MON_AUG), int'(MON_OCT), int'(MON_DEC): len = 31;
            default: len = 0;
        endcase
        return len;
    endfunction

    // Applies one command to the held date and returns the result the block must produce.
    function automatic date_result_t apply_date_command(input date_cmd_t c);
        date_result_t r;
        int           y;
        int           m;
        int           d;
        int           doy;
        int           off;
        bit           done;
        done = 1'b0;
        if (c.cmd == CMD_LOAD) begin
            y = int'(c.year);
            m = int'(c.month);
            d = int'(c.day);
            if (y <= YEAR_MAX && d >= 1 && d <= days_in_month(y, m)) begin
                held_year  = c.year;
                held_month = c.month;
                held_day   = c.day;
                done       = 1'b1;
            end
        end else begin
            // Offsets past a full year are clamped rather than refused.
            off = int'(c.offset);
            if (off > OFF_LIMIT) off = OFF_LIMIT;
            if (off < -OFF_LIMIT) off = -OFF_LIMIT;
            y   = int'(held_year);
            doy = int'(held_day) + off;
            for (m = 1; m < int'(held_month); m++)
                doy += days_in_month(y, m);
            // At most one year boundary is crossed in either direction.
            if (doy > days_in_year(y)) begin
                doy -= days_in_year(y);
                y++;
            end
            if (doy < 1) begin
                y--;
                doy += days_in_year(y);
            end
            if (y >= 0 && y <= YEAR_MAX) begin
                m = 1;
                while (m < 12 && doy > days_in_month(y, m)) begin
                    doy -= days_in_month(y, m);
                    m++;
                end
                held_year  = YEAR_W'(y);
                held_month = MONTH_W'(m);
                held_day   = DAY_W'(doy);
                done       = 1'b1;
            end
        end
        r.year  = held_year;
        r.month = held_month;
        r.day   = held_day;
        r.ok    = done;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Item builders. Fields that a command ignores still carry random bits.
    // ------------------------------------------------------------------

    function automatic date_cmd_t load_cmd(input int y, input int m, input int d);
        date_cmd_t c;
        c.cmd    = CMD_LOAD;
        c.year   = YEAR_W'(y);
        c.month  = MONTH_W'(m);
        c.day    = DAY_W'(d);
        c.offset = OFF_W'($urandom_range(0, 1023));
        return c;
    endfunction

    function automatic date_cmd_t advance_cmd(input int off);
        date_cmd_t c;
        c.cmd    = CMD_ADV;
        c.year   = YEAR_W'($urandom_range(0, 16383));
        c.month  = MONTH_W'($urandom_range(0, 15));
        c.day    = DAY_W'($urandom_range(0, 31));
        c.offset = OFF_W'(off);
        return c;
    endfunction

    // A valid date, leaning toward the ends of the year range, century years and month ends.
    function automatic date_cmd_t random_valid_load();
        int y;
        int m;
        int len;
        int d;
        case ($urandom_range(0, 9))
            0:       y = $urandom_range(0, 3);
            1:       y = $urandom_range(YEAR_MAX - 3, YEAR_MAX);
            2:       y = 100 * $urandom_range(0, YEAR_MAX / 100);
            default: y = $urandom_range(0, YEAR_MAX);
        endcase
        m   = $urandom_range(1, 12);
        len = days_in_month(y, m);
        if ($urandom_range(0, 9) < 3)
            d = len - $urandom_range(0, 2);
        else
            d = $urandom_range(1, len);
        return load_cmd(y, m, d);
    endfunction

    // ------------------------------------------------------------------
    // Sender: one item per call. Valid stays high after acceptance so that a
    // following item can go out back to back; it drops only on an idle cycle.
    // ------------------------------------------------------------------
    task automatic send_command(input date_cmd_t c);
        while (gaps_on && $urandom_range(0, 99) < 9) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid    <= 1'b1;
        command     <= c.cmd;
        year_in     <= c.year;
        month_in    <= c.month;
        day_in      <= c.day;
        offset_days <= c.offset;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        expected_dates.push_back(apply_date_command(c));
    endtask

    // ------------------------------------------------------------------
    // Receiver: checks every accepted result against the oldest expectation
    // and stalls out_ready at random.
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, actual %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge clk) begin : result_checker
        date_result_t want;
        if (out_valid && out_ready) begin
            if (expected_dates.size() == 0) begin
                $error("unexpected result %0d-%0d-%0d ok=%0b",
                       year_out, month_out, day_out, ok);
                error_count++;
            end else begin
                want = expected_dates.pop_front();
                check_field("year_out", want.year, year_out);
                check_field("month_out", want.month, month_out);
                check_field("day_out", want.day, day_out);
                check_field("ok", want.ok, ok);
            end
        end
        out_ready <= !(gaps_on && ($urandom_range(0, 99) < 9));
    end

    // ------------------------------------------------------------------
    // Tests.
    // ------------------------------------------------------------------

    // A zero advance right after reset exposes the reset date.
    task automatic test_reset_date();
        send_command(advance_cmd(0));
    endtask

    // Loads at the edges of every field, including the leap-day rules.
    task automatic test_load_limits();
        send_command(load_cmd(0, 1, 1));
        send_command(load_cmd(YEAR_MAX, 12, 31));
        send_command(load_cmd(YEAR_MAX + 1, 6, 15));   // year just past the range
        send_command(load_cmd(16383, 1, 1));           // all year bits set
        send_command(load_cmd(2020, 0, 10));           // month zero
        send_command(load_cmd(2020, 13, 1));
        send_command(load_cmd(2020, 15, 31));
        send_command(load_cmd(2021, 3, 0));            // day zero
        send_command(load_cmd(2021, 4, 31));           // day past a 30-day month
        send_command(load_cmd(2000, 2, 29));           // leap by the 400 rule
        send_command(load_cmd(1900, 2, 29));           // plain by the 100 rule
        send_command(load_cmd(2100, 2, 29));
        send_command(load_cmd(2024, 2, 29));
        send_command(load_cmd(2023, 1, 31));
    endtask

    // Advances at both ends of the year range, full-year offsets and clamping.
    task automatic test_advance_limits();
        send_command(load_cmd(YEAR_MAX, 12, 31));
        send_command(advance_cmd(1));                  // refused: past the last year
        send_command(advance_cmd(-OFF_LIMIT));
        send_command(load_cmd(0, 1, 1));
        send_command(advance_cmd(-1));                 // refused: before year zero
        send_command(advance_cmd(OFF_LIMIT));          // year zero is a leap year
        send_command(advance_cmd(OFF_LIMIT));
        send_command(load_cmd(2000, 12, 31));
        send_command(advance_cmd(511));                // clamped to a full year forward
        send_command(advance_cmd(-512));               // clamped to a full year back
    endtask

    // Mostly valid loads followed by walks of advances; the rest are malformed
    // loads and items with every field random. A middle stretch runs with no idling.
    task automatic test_random_walk(input int count);
        date_cmd_t c;
        int        pick;
        int        len;
        for (int n = 0; n < count; n++) begin
            gaps_on = !(n >= count * 2 / 5 && n < count * 3 / 5);
            pick    = $urandom_range(0, 99);
            if (pick < 20) begin
                c = random_valid_load();
            end else if (pick < 30) begin
                // Start from a valid date and break exactly one field.
                c   = random_valid_load();
                len = days_in_month(int'(c.year), int'(c.month));
                case ($urandom_range(0, 3))
                    0: c.year  = YEAR_W'($urandom_range(YEAR_MAX + 1, 16383));
                    1: c.month = ($urandom_range(0, 1) == 0) ? MONTH_W'(0)
                                                             : MONTH_W'($urandom_range(13, 15));
                    2: c.day   = DAY_W'(0);
                    default: c.day = (len < 31) ? DAY_W'($urandom_range(len + 1, 31))
                                                : DAY_W'(0);
                endcase
            end else if (pick < 35) begin
                c.cmd    = logic'($urandom_range(0, 1));
                c.year   = YEAR_W'($urandom_range(0, 16383));
                c.month  = MONTH_W'($urandom_range(0, 15));
                c.day    = DAY_W'($urandom_range(0, 31));
                c.offset = OFF_W'($urandom_range(0, 1023));
            end else begin
                pick = $urandom_range(0, 19);
                if (pick == 0)
                    c = advance_cmd(($urandom_range(0, 1) == 0) ? OFF_LIMIT : -OFF_LIMIT);
                else if (pick < 3)
                    c = advance_cmd($urandom_range(0, 1023));   // any bit pattern
                else
                    c = advance_cmd($urandom_range(0, 2 * OFF_LIMIT) - OFF_LIMIT);
            end
            send_command(c);
        end
        gaps_on = 1'b1;
    endtask

    // ------------------------------------------------------------------
    // Run order: reset, directed tests, the random walk, then drain.
    // ------------------------------------------------------------------
    initial begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_reset_date();
        test_load_limits();
        test_advance_limits();
        test_random_walk(RANDOM_ITEMS);

        // The last item has been accepted; stop offering and wait for its result.
        in_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);

        if (error_count == 0)
            $display("calendar_date_set_and_advance_tb: clean");
        else
            $display("calendar_date_set_and_advance_tb: errors");
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #(RUN_LIMIT);
        $display("calendar_date_set_and_advance_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
